FILE: rtl/core/rsbp_pkg.sv
// Shared types and constants for the rectangle slot table.
package rsbp_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_DUMP  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STS_REPLACED  = 3'd0,
    STS_ALLOCATED = 3'd1,
    STS_DROPPED   = 3'd2,
    STS_CLEARED   = 3'd3,
    STS_ENTRY     = 3'd4,
    STS_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] width;
    logic signed [15:0] height;
    logic        [23:0] color;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic        [3:0]  slot_index;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_width;
    logic signed [15:0] out_height;
    logic        [23:0] out_color;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic        [23:0] rgb;
  } slot_rec_t;

  typedef struct packed {
    logic hit;
    logic full;
  } cam_flags_t;

endpackage

FILE: rtl/core/rsbp_key_cam.sv
// Slot used bits and position keys with parallel key match and free-slot search.
module rsbp_key_cam #(
  parameter int SLOT_COUNT = 16,
  parameter int IDX_W      = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [15:0]       key_x,
  input  logic signed [15:0]       key_y,
  output rsbp_pkg::cam_flags_t     flags,
  output logic [IDX_W-1:0]         sel_idx,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic                     clr,
  output logic [SLOT_COUNT-1:0]    used
);
  import rsbp_pkg::*;

  logic [SLOT_COUNT-1:0] used_r;
  logic [15:0]           key_x_r [SLOT_COUNT];
  logic [15:0]           key_y_r [SLOT_COUNT];
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic                  found_free;
  logic [IDX_W-1:0]      free_idx;

  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    found_free = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (used_r[i] && (key_x_r[i] == key_x) && (key_y_r[i] == key_y)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!used_r[i]) begin
        found_free = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign flags.hit  = hit;
  assign flags.full = !found_free;
  assign sel_idx    = hit ? hit_idx : free_idx;
  assign used       = used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (clr) begin
      used_r <= '0;
    end else if (wr_en) begin
      used_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !clr) begin
      key_x_r[wr_idx] <= key_x;
      key_y_r[wr_idx] <= key_y;
    end
  end

endmodule

FILE: rtl/core/rsbp_slot_ram.sv
// Synchronous slot record memory with one write port and one registered read port.
module rsbp_slot_ram #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  rsbp_pkg::slot_rec_t  wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output rsbp_pkg::slot_rec_t  rd_data
);
  import rsbp_pkg::*;

  slot_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/rect_slot_table_by_position_unit.sv
// Top level of the rectangle slot table: command sequencer, key match and record memory.
//
// Channel  Ports                   Handshake
// in       start, busy, in_item    item taken when start && !busy
// out      out_valid, out_item     one-cycle strobe, no backpressure
//
// Put and clear: accept, then key match and table write.
// Dump: accept, then scan the slots in order through the record memory read port, flush the
// held entry, and take an extra step when the last scanned slot is used.
// Unused command code: accepted, no result.
// Reset (rst_n low, synchronous) empties the table at once; no clearing pass.
// The receiver cannot stall; each result shows for one cycle only.
module rect_slot_table_by_position_unit #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rsbp_pkg::in_item_t  in_item,
  output logic                out_valid,
  output rsbp_pkg::out_item_t out_item
);
  import rsbp_pkg::*;

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SCAN_W = IDX_W + 1;
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_RESULTS);

  function automatic logic [3:0] idx4(input logic [IDX_W-1:0] idx);
    logic [IDX_W+3:0] ext;
    ext = {4'b0000, idx};
    return ext[3:0];
  endfunction

  state_t              state_r, state_nxt;
  in_item_t            item_r;
  logic [SCAN_W-1:0]   scan_r, scan_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                held_v_r, held_v_nxt;
  slot_rec_t           held_r, held_nxt;
  logic [IDX_W-1:0]    held_idx_r, held_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  cam_flags_t          flags;
  logic [IDX_W-1:0]    sel_idx;
  logic [SLOT_COUNT-1:0] used;
  logic                cam_wr;
  logic                cam_clr;
  logic                ram_wr;
  logic                ram_rd;
  slot_rec_t           wr_rec;
  slot_rec_t           rd_data;
  logic [IDX_W-1:0]    scan_idx;
  logic                scan_done;
  logic                issue;
  logic                accept;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign scan_idx  = scan_r[IDX_W-1:0];
  assign scan_done = (scan_r == SCAN_END) || (cnt_r == CNT_MAX);
  assign issue     = !scan_done && used[scan_idx];

  assign wr_rec.x   = item_r.pos_x;
  assign wr_rec.y   = item_r.pos_y;
  assign wr_rec.w   = item_r.width;
  assign wr_rec.h   = item_r.height;
  assign wr_rec.rgb = item_r.color;

  rsbp_key_cam #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_cam (
    .clk     (clk),
    .rst_n   (rst_n),
    .key_x   (item_r.pos_x),
    .key_y   (item_r.pos_y),
    .flags   (flags),
    .sel_idx (sel_idx),
    .wr_en   (cam_wr),
    .wr_idx  (sel_idx),
    .clr     (cam_clr),
    .used    (used)
  );

  rsbp_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (sel_idx),
    .wr_data (wr_rec),
    .rd_en   (ram_rd),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = rd_pend_r;
    rd_idx_nxt    = rd_idx_r;
    held_v_nxt    = held_v_r;
    held_nxt      = held_r;
    held_idx_nxt  = held_idx_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    cam_wr        = 1'b0;
    cam_clr       = 1'b0;
    ram_wr        = 1'b0;
    ram_rd        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          scan_nxt    = '0;
          cnt_nxt     = '0;
          rd_pend_nxt = 1'b0;
          held_v_nxt  = 1'b0;
          case (in_item.command)
            CMD_PUT:   state_nxt = S_EXEC;
            CMD_CLEAR: state_nxt = S_EXEC;
            CMD_DUMP:  state_nxt = S_DUMP;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_EXEC: begin
        state_nxt         = S_IDLE;
        out_valid_nxt     = 1'b1;
        out_item_nxt.last = 1'b1;
        case (item_r.command)
          CMD_PUT: begin
            if (flags.hit || !flags.full) begin
              cam_wr                  = 1'b1;
              ram_wr                  = 1'b1;
              out_item_nxt.slot_index = idx4(sel_idx);
              if (flags.hit) begin
                out_item_nxt.status = STS_REPLACED;
              end else begin
                out_item_nxt.status = STS_ALLOCATED;
              end
            end else begin
              out_item_nxt.status = STS_DROPPED;
            end
          end
          CMD_CLEAR: begin
            cam_clr             = 1'b1;
            out_item_nxt.status = STS_CLEARED;
          end
          default: begin
            out_valid_nxt = 1'b0;
          end
        endcase
      end
      S_DUMP: begin
        rd_pend_nxt = 1'b0;
        if (!scan_done) begin
          scan_nxt = scan_r + 1'b1;
          if (issue) begin
            ram_rd      = 1'b1;
            cnt_nxt     = cnt_r + 1'b1;
            rd_pend_nxt = 1'b1;
            rd_idx_nxt  = scan_idx;
          end
        end
        if (rd_pend_r || scan_done) begin
          if (held_v_r) begin
            out_valid_nxt           = 1'b1;
            out_item_nxt.status     = STS_ENTRY;
            out_item_nxt.slot_index = idx4(held_idx_r);
            out_item_nxt.out_x      = held_r.x;
            out_item_nxt.out_y      = held_r.y;
            out_item_nxt.out_width  = held_r.w;
            out_item_nxt.out_height = held_r.h;
            out_item_nxt.out_color  = held_r.rgb;
          end
          if (rd_pend_r) begin
            held_nxt     = rd_data;
            held_idx_nxt = rd_idx_r;
            held_v_nxt   = 1'b1;
          end else begin
            out_valid_nxt     = 1'b1;
            out_item_nxt.last = 1'b1;
            if (!held_v_r) begin
              out_item_nxt.status = STS_EMPTY;
            end
            held_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    rd_idx_r   <= rd_idx_nxt;
    held_r     <= held_nxt;
    held_idx_r <= held_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_put_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.command == CMD_PUT)) |=> ##1 out_valid_r)
    else $error("put item gave no result two cycles after accept");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.status == STS_CLEARED)) |-> (used == '0))
    else $error("table not empty after clear");

  a_write_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
    (cam_wr && !cam_clr) |=> used[$past(sel_idx)])
    else $error("written slot not marked used");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("dump read count past result limit");

  a_read_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == S_DUMP))
    else $error("record read pending outside dump");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.status != STS_ENTRY)) |-> out_item_r.last)
    else $error("single-result item not marked last");

endmodule
